[hdl/cae_pkg.sv]
// Shared types and constants for the curved ADSR envelope.
// Used by cae_div, cae_tables and curved_adsr_envelope; depends on nothing.
package cae_pkg;

    localparam int TIMER_W = 32;
    localparam int TAB_W   = 31;

    typedef logic [TIMER_W-1:0] t_timer;
    typedef logic [TAB_W-1:0]   t_tab_word;

    // Table select for the shared lookup port
    typedef enum logic {
        TAB_LOG,
        TAB_EXP
    } t_tab_sel;

    // Register index on the configuration port
    typedef enum logic [2:0] {
        REG_ATTACK_SET  = 3'd0,
        REG_DECAY_SET   = 3'd1,
        REG_SUSTAIN     = 3'd2,
        REG_RELEASE_SET = 3'd3,
        REG_ATTACK_CRV  = 3'd4,
        REG_DECAY_CRV   = 3'd5,
        REG_RELEASE_CRV = 3'd6
    } t_reg_idx;

    // Divider request and response
    typedef struct packed {
        logic   start;
        t_timer num;
        t_timer den;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_timer quot;
    } t_div_rsp;

endpackage

[hdl/cae_div.sv]
// Radix-2 restoring divider forming floor(num * 2^32 / den) for num < den.
// Depends on cae_pkg for the request and response types.
module cae_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cae_pkg::t_div_req i_req,
    output cae_pkg::t_div_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [4:0]                   r_cnt;
    logic [cae_pkg::TIMER_W-1:0]  r_rem;
    logic [cae_pkg::TIMER_W-1:0]  r_den;
    logic [cae_pkg::TIMER_W-1:0]  r_quot;

    logic [cae_pkg::TIMER_W:0]    w_rem2;
    logic [cae_pkg::TIMER_W:0]    w_diff;
    logic                         w_ge;

    // Trial subtraction of one quotient bit
    always_comb begin
        w_rem2 = {r_rem, 1'b0};
        w_ge   = (w_rem2 >= {1'b0, r_den});
        w_diff = w_rem2 - {1'b0, r_den};
    end

    // Step one bit per cycle; remainder always stays below the divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[cae_pkg::TIMER_W-1:0] : w_rem2[cae_pkg::TIMER_W-1:0];
                r_quot <= {r_quot[cae_pkg::TIMER_W-2:0], w_ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'(cae_pkg::TIMER_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[hdl/cae_tables.sv]
// Log2(1+x) and 2^(-x) lookup tables in Q30, built at elaboration, one read port.
// Depends on cae_pkg for the table word and select types.
module cae_tables #(
    parameter int LOG_TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  cae_pkg::t_tab_sel                    i_sel,
    input  logic [$clog2(LOG_TABLE_DEPTH+1)-1:0] i_addr,
    output cae_pkg::t_tab_word                   o_data
);

    typedef cae_pkg::t_tab_word t_tab [0:LOG_TABLE_DEPTH];

    // Integer square root, bit-pair method
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (b > v) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2(1 + i/depth) by repeated squaring
    function automatic t_tab build_log();
        t_tab        tab;
        logic [63:0] z;
        logic [63:0] acc;
        for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
            z   = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
            acc = '0;
            if (z >= (64'd2 << 30)) begin
                acc = 64'd1 << 30;
            end else begin
                for (int j = 29; j >= 0; j--) begin
                    z = (z * z) >> 30;
                    if (z >= (64'd2 << 30)) begin
                        z      = z >> 1;
                        acc[j] = 1'b1;
                    end
                end
            end
            tab[i] = acc[cae_pkg::TAB_W-1:0];
        end
        return tab;
    endfunction

    // 2^(-i/depth) as a product of square roots of two
    function automatic t_tab build_exp();
        t_tab        tab;
        logic [63:0] roots [0:30];
        logic [63:0] g;
        logic [63:0] p;
        roots[0] = 64'd2 << 30;
        for (int k = 1; k <= 30; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
            g = (64'(LOG_TABLE_DEPTH - i) << 30) / LOG_TABLE_DEPTH;
            p = g[30] ? (64'd2 << 30) : (64'd1 << 30);
            for (int k = 1; k <= 30; k++) begin
                if (g[30-k]) p = (p * roots[k]) >> 30;
            end
            tab[i] = cae_pkg::TAB_W'((p + 64'd1) >> 1);
        end
        return tab;
    endfunction

    localparam t_tab LOG_TAB = build_log();
    localparam t_tab EXP_TAB = build_exp();

    cae_pkg::t_tab_word r_data;

    // Registered read
    always_ff @(posedge i_clk) begin
        r_data <= (i_sel == cae_pkg::TAB_EXP) ? EXP_TAB[i_addr] : LOG_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

[hdl/curved_adsr_envelope.sv]
// Curved ADSR envelope: sequencer, shared multiplier, registers and APB port.
// A gate request goes straight to result hand-over; a tick that evaluates a curve also
// runs the 32-step divider, the one-bit normaliser and three passes through the single
// table port. Any result can be held by output stalls.
// One request at a time. Reset (synchronous, active low) clears timers, gate and level.
// Sustain resets to full. Depends on cae_pkg, cae_div and cae_tables.
module curved_adsr_envelope #(
    parameter int LOG_TABLE_DEPTH = 1024,
    parameter int MAX_STEP_US     = 50000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: tuser [0] req_type
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [0] gate_on, [40:1] now_us, [47:41] zero
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    // result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] level
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDXW   = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int DT_W   = $clog2(MAX_STEP_US + 1);
    localparam int DUR_W  = 21;
    localparam int MA_W   = 32;
    localparam int MB_W   = 34;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SEG_SCALE = 1400000;
    localparam int SEG_BASE  = 4000;
    localparam int CURVE_K   = 2722996;
    localparam logic [41:0] CURVE_OFF = 42'((64'd1 << 40) - 64'd32768 * 64'd2722996);

    typedef enum logic [4:0] {
        S_IDLE, S_DT, S_ACC, S_DA, S_DB, S_DC, S_SEL, S_SH0, S_DIVW, S_NORM,
        S_LM, S_LI, S_RD0, S_RD1, S_RD2, S_LIP, S_LG, S_CM, S_CU, S_EM,
        S_EI, S_EIP, S_EV, S_YM, S_Y, S_LVL, S_LV2, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        SEG_ATT,
        SEG_DEC,
        SEG_REL
    } t_seg;

    // Configuration registers
    logic [15:0] r_atk_set, r_dec_set, r_sus, r_rel_set;
    logic [15:0] r_atk_crv, r_dec_crv, r_rel_crv;

    // Envelope state
    logic                 r_gate;
    logic [39:0]          r_last;
    logic                 r_seen;
    cae_pkg::t_timer      r_gt;
    cae_pkg::t_timer      r_rt;
    logic [15:0]          r_rs;
    logic [15:0]          r_lvl_cur;

    // Sequencer and work registers
    t_state               r_state;
    logic [39:0]          r_now;
    logic                 r_is_tick;
    logic [DT_W-1:0]      r_dt;
    logic [DUR_W-1:0]     r_dur0, r_dur1;
    t_seg                 r_seg;
    cae_pkg::t_timer      r_t, r_d;
    logic [15:0]          r_crv;
    logic [31:0]          r_x;
    logic [4:0]           r_shift;
    logic [30:0]          r_w;
    logic [IDXW-1:0]      r_raddr;
    cae_pkg::t_tab_sel    r_rsel;
    cae_pkg::t_tab_word   r_a, r_b;
    logic [31:0]          r_lg;
    logic [MB_W-1:0]      r_e;
    logic [23:0]          r_f;
    logic signed [4:0]    r_cn;
    logic [4:0]           r_n;
    logic                 r_pass;
    logic [16:0]          r_sh;
    logic [15:0]          r_lvl_new;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_div_start;
    logic                 r_ovalid;
    logic [15:0]          r_odata;

    cae_pkg::t_div_req    w_div_req;
    cae_pkg::t_div_rsp    w_div_rsp;
    cae_pkg::t_tab_word   w_rom;

    logic [MA_W-1:0]      w_ma;
    logic [MB_W-1:0]      w_mb;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_acc;

    // Shared divider
    assign w_div_req.start = r_div_start;
    assign w_div_req.num   = r_t;
    assign w_div_req.den   = r_d;

    cae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Shared table port
    cae_tables #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_tables (
        .i_clk  (i_clk),
        .i_sel  (r_rsel),
        .i_addr (r_raddr),
        .o_data (w_rom)
    );

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atk_set <= '0;
            r_dec_set <= '0;
            r_sus     <= 16'hFFFF;
            r_rel_set <= '0;
            r_atk_crv <= '0;
            r_dec_crv <= '0;
            r_rel_crv <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (cae_pkg::t_reg_idx'(paddr[4:2]))
                cae_pkg::REG_ATTACK_SET:  r_atk_set <= pwdata[15:0];
                cae_pkg::REG_DECAY_SET:   r_dec_set <= pwdata[15:0];
                cae_pkg::REG_SUSTAIN:     r_sus     <= pwdata[15:0];
                cae_pkg::REG_RELEASE_SET: r_rel_set <= pwdata[15:0];
                cae_pkg::REG_ATTACK_CRV:  r_atk_crv <= pwdata[15:0];
                cae_pkg::REG_DECAY_CRV:   r_dec_crv <= pwdata[15:0];
                cae_pkg::REG_RELEASE_CRV: r_rel_crv <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cae_pkg::t_reg_idx'(paddr[4:2]))
            cae_pkg::REG_ATTACK_SET:  prdata = 32'(r_atk_set);
            cae_pkg::REG_DECAY_SET:   prdata = 32'(r_dec_set);
            cae_pkg::REG_SUSTAIN:     prdata = 32'(r_sus);
            cae_pkg::REG_RELEASE_SET: prdata = 32'(r_rel_set);
            cae_pkg::REG_ATTACK_CRV:  prdata = 32'(r_atk_crv);
            cae_pkg::REG_DECAY_CRV:   prdata = 32'(r_dec_crv);
            cae_pkg::REG_RELEASE_CRV: prdata = 32'(r_rel_crv);
            default:                  prdata = '0;
        endcase
    end

    // Stream handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Multiplier operand selection by step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_DA: begin
                w_ma = MA_W'(r_gate ? r_atk_set : r_rel_set);
                w_mb = MB_W'(SEG_SCALE);
            end
            S_DB: begin
                w_ma = MA_W'(r_dec_set);
                w_mb = MB_W'(SEG_SCALE);
            end
            S_LM: begin
                w_ma = MA_W'(r_x[30:0]);
                w_mb = MB_W'(LOG_TABLE_DEPTH);
            end
            S_LIP: begin
                w_ma = (r_b > r_a) ? MA_W'(r_b - r_a) : '0;
                w_mb = MB_W'(r_w);
            end
            S_CM: begin
                w_ma = MA_W'(r_crv ^ 16'h8000);
                w_mb = MB_W'(CURVE_K);
            end
            S_EM: begin
                w_ma = MA_W'(r_f);
                w_mb = MB_W'(LOG_TABLE_DEPTH);
            end
            S_EIP: begin
                w_ma = (r_a > r_b) ? MA_W'(r_a - r_b) : '0;
                w_mb = MB_W'(r_w[23:0]);
            end
            S_YM: begin
                w_ma = r_lg;
                w_mb = r_e;
            end
            S_LVL: begin
                if (r_seg == SEG_DEC) begin
                    w_ma = MA_W'(17'h10000 - 17'(r_sus));
                    w_mb = MB_W'(r_sh);
                end else begin
                    w_ma = MA_W'(r_rs);
                    w_mb = MB_W'(17'h10000 - r_sh);
                end
            end
            default: ;
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // Step arithmetic around the multiplier
    logic [39:0]           w_diff40, w_dt_big;
    logic [DT_W-1:0]       w_dt_cap;
    logic [32:0]           w_tsum;
    cae_pkg::t_timer       w_tsat;
    logic [37:0]           w_dr;
    logic [DUR_W-1:0]      w_dur;
    logic [DUR_W:0]        w_ad_dd;
    logic [PROD_W-1:0]     w_p31, w_p24;
    logic [IDXW-1:0]       w_lidx, w_eidx;
    logic [31:0]           w_l;
    logic [35:0]           w_l30;
    logic [41:0]           w_u;
    logic signed [7:0]     w_n8;
    logic signed [4:0]     w_ncl;
    logic [30:0]           w_v;
    logic [3:0]            w_lsh, w_rsh;
    logic [38:0]           w_e;
    logic [5:0]            w_s;
    logic [37:0]           w_vr;
    logic [16:0]           w_shv;
    logic [31:0]           w_y;
    logic [33:0]           w_rnd;
    logic [17:0]           w_dlvl;

    always_comb begin
        // elapsed time, ignored when time goes backwards or on the first tick
        w_diff40 = r_now - r_last;
        w_dt_big = (r_seen && (r_now > r_last)) ? w_diff40 : '0;
        w_dt_cap = (w_dt_big > 40'(MAX_STEP_US)) ? DT_W'(MAX_STEP_US) : w_dt_big[DT_W-1:0];
        w_tsum   = {1'b0, (r_gate ? r_gt : r_rt)} + 33'(r_dt);
        w_tsat   = w_tsum[32] ? '1 : w_tsum[31:0];
        // segment duration from setting product
        w_dr     = r_prod[37:0] + 38'd32768;
        w_dur    = DUR_W'(w_dr[37:16]) + DUR_W'(SEG_BASE);
        w_ad_dd  = {1'b0, r_dur0} + {1'b0, r_dur1};
        // table indices, held below the last interval
        w_p31    = r_prod >> 31;
        w_p24    = r_prod >> 24;
        w_lidx   = (w_p31 >= PROD_W'(LOG_TABLE_DEPTH)) ? IDXW'(LOG_TABLE_DEPTH - 1)
                                                       : w_p31[IDXW-1:0];
        w_eidx   = (w_p24 >= PROD_W'(LOG_TABLE_DEPTH)) ? IDXW'(LOG_TABLE_DEPTH - 1)
                                                       : w_p24[IDXW-1:0];
        // -log2 in Q30 from shift count and interpolated mantissa log
        w_l      = 32'(r_a) + 32'(r_prod >> 31);
        w_l30    = ((36'(r_shift) + 36'd1) << 30) - 36'(w_l);
        // curve exponent split into integer and fraction of 2^-y
        w_u      = r_prod[41:0] + CURVE_OFF + 42'd1024;
        w_n8     = $signed({1'b0, w_u[41:35]}) - 8'sd32;
        if (w_n8 < -8'sd8)     w_ncl = -5'sd8;
        else if (w_n8 > 8'sd8) w_ncl = 5'sd8;
        else                   w_ncl = 5'(w_n8);
        // interpolated 2^-f
        w_v      = r_a - 31'(r_prod >> 24);
        // curve range keeps the shift within minus three to plus two, so e fits 34 bits
        w_lsh    = 4'(-r_cn);
        w_rsh    = 4'(r_cn);
        w_e      = (r_cn < 0) ? (39'(w_v) << w_lsh) : (39'(w_v) >> w_rsh);
        w_s      = 6'd14 + 6'(r_n);
        w_vr     = 38'(w_v) + (38'd1 << (w_s - 6'd1));
        w_shv    = 17'(w_vr >> w_s);
        w_y      = 32'((r_prod + PROD_W'(64'h8000_0000)) >> 32);
        // level scaling
        w_rnd    = r_prod[33:0] + 34'd32768;
        w_dlvl   = 18'h10000 - w_rnd[33:16];
    end

    // Sequencer, state and result register
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_gate      <= 1'b0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_gt        <= '0;
            r_rt        <= '0;
            r_rs        <= '0;
            r_lvl_cur   <= '0;
        end else begin
            // raise the result on hand-over, drop it once taken
            if (r_state == S_FIN && (!r_ovalid || m_axis_tready)) r_ovalid <= 1'b1;
            else if (m_axis_tready)                                r_ovalid <= 1'b0;
            // start the divider when a nonzero fraction below one is needed
            r_div_start <= (r_state == S_SH0) && (r_t != '0) && (r_t < r_d);
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_now <= s_axis_tdata[40:1];
                        if (s_axis_tuser[0]) begin
                            // gate change: start attack or latch release
                            if (s_axis_tdata[0] && !r_gate) r_gt <= '0;
                            if (!s_axis_tdata[0] && r_gate) begin
                                r_rt <= '0;
                                r_rs <= r_lvl_cur;
                            end
                            r_gate    <= s_axis_tdata[0];
                            r_is_tick <= 1'b0;
                            r_lvl_new <= r_lvl_cur;
                            r_state   <= S_FIN;
                        end else begin
                            r_is_tick <= 1'b1;
                            r_state   <= S_DT;
                        end
                    end
                end
                S_DT: begin
                    r_dt    <= w_dt_cap;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_last <= r_now;
                    r_seen <= 1'b1;
                    if (r_gate) r_gt <= w_tsat;
                    else        r_rt <= w_tsat;
                    r_state <= S_DA;
                end
                S_DA: r_state <= S_DB;
                S_DB: begin
                    r_dur0  <= w_dur;
                    r_state <= S_DC;
                end
                S_DC: begin
                    r_dur1  <= w_dur;
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    // pick the segment and its timer
                    if (r_gate) begin
                        if (r_gt < 32'(r_dur0)) begin
                            r_seg   <= SEG_ATT;
                            r_t     <= r_gt;
                            r_d     <= 32'(r_dur0);
                            r_crv   <= r_atk_crv;
                            r_state <= S_SH0;
                        end else if (r_gt < 32'(w_ad_dd)) begin
                            r_seg   <= SEG_DEC;
                            r_t     <= r_gt - 32'(r_dur0);
                            r_d     <= 32'(r_dur1);
                            r_crv   <= r_dec_crv;
                            r_state <= S_SH0;
                        end else begin
                            r_lvl_new <= r_sus;
                            r_state   <= S_FIN;
                        end
                    end else begin
                        if (r_rt >= 32'(r_dur0)) begin
                            r_lvl_new <= '0;
                            r_state   <= S_FIN;
                        end else begin
                            r_seg   <= SEG_REL;
                            r_t     <= r_rt;
                            r_d     <= 32'(r_dur0);
                            r_crv   <= r_rel_crv;
                            r_state <= S_SH0;
                        end
                    end
                end
                S_SH0: begin
                    if (r_t == '0) begin
                        r_sh    <= '0;
                        r_state <= S_LVL;
                    end else if (r_t >= r_d) begin
                        r_sh    <= 17'h10000;
                        r_state <= S_LVL;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (w_div_rsp.done) begin
                        r_x     <= w_div_rsp.quot;
                        r_shift <= '0;
                        if (w_div_rsp.quot == '0) begin
                            r_sh    <= '0;
                            r_state <= S_LVL;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // normalise one bit a cycle
                    if (r_x[31]) begin
                        r_state <= S_LM;
                    end else begin
                        r_x     <= {r_x[30:0], 1'b0};
                        r_shift <= r_shift + 5'd1;
                    end
                end
                S_LM: r_state <= S_LI;
                S_LI: begin
                    r_w     <= r_prod[30:0];
                    r_raddr <= w_lidx;
                    r_rsel  <= cae_pkg::TAB_LOG;
                    r_state <= S_RD0;
                end
                S_RD0: begin
                    r_raddr <= r_raddr + IDXW'(1);
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_a     <= w_rom;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_b     <= w_rom;
                    r_state <= (r_rsel == cae_pkg::TAB_LOG) ? S_LIP : S_EIP;
                end
                S_LIP: r_state <= S_LG;
                S_LG: begin
                    r_lg    <= 32'((w_l30 + 36'd8) >> 4);
                    r_state <= S_CM;
                end
                S_CM: r_state <= S_CU;
                S_CU: begin
                    r_cn    <= w_ncl;
                    r_f     <= w_u[34:11];
                    r_pass  <= 1'b0;
                    r_state <= S_EM;
                end
                S_EM: r_state <= S_EI;
                S_EI: begin
                    r_w     <= 31'(r_prod[23:0]);
                    r_raddr <= w_eidx;
                    r_rsel  <= cae_pkg::TAB_EXP;
                    r_state <= S_RD0;
                end
                S_EIP: r_state <= S_EV;
                S_EV: begin
                    if (!r_pass) begin
                        r_e     <= w_e[MB_W-1:0];
                        r_state <= S_YM;
                    end else begin
                        r_sh    <= w_shv;
                        r_state <= S_LVL;
                    end
                end
                S_YM: r_state <= S_Y;
                S_Y: begin
                    // exponent of 24 octaves or more rounds to zero
                    if (w_y >= (32'd24 << 24)) begin
                        r_sh    <= '0;
                        r_state <= S_LVL;
                    end else begin
                        r_n     <= w_y[28:24];
                        r_f     <= w_y[23:0];
                        r_pass  <= 1'b1;
                        r_state <= S_EM;
                    end
                end
                S_LVL: begin
                    if (r_seg == SEG_ATT) begin
                        r_lvl_new <= (r_sh > 17'd65535) ? 16'hFFFF : r_sh[15:0];
                        r_state   <= S_FIN;
                    end else begin
                        r_state <= S_LV2;
                    end
                end
                S_LV2: begin
                    if (r_seg == SEG_DEC) begin
                        r_lvl_new <= (w_dlvl > 18'd65535) ? 16'hFFFF : w_dlvl[15:0];
                    end else begin
                        r_lvl_new <= w_rnd[31:16];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hand over once the result slot is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_odata  <= r_lvl_new;
                        if (r_is_tick) begin
                            r_lvl_cur <= r_lvl_new;
                            if (r_gate) r_rs <= r_lvl_new;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIVW)
        else $error("divider done outside wait step");

    // Mantissa is normalised before the log lookup
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LM |-> r_x[31])
        else $error("mantissa not normalised");

    // A gate request goes straight to result hand-over
    a_gate_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && s_axis_tuser[0]) |=> r_state == S_FIN)
        else $error("gate request took the tick path");

endmodule
